FILE: hw/rtl/ddmm_pkg.sv
// ============================================================================
// ddmm_pkg: shared types and constants of the DDMM.MMMM coordinate formatter
// Decoded word layout between the front pipeline, the queue and the
// character sequencer, and the ASCII codes the sequencer emits.
// ============================================================================
package ddmm_pkg;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_N     = 8'h4E;
   localparam logic [7:0] CHAR_S     = 8'h53;
   localparam logic [7:0] CHAR_E     = 8'h45;
   localparam logic [7:0] CHAR_W     = 8'h57;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;

   typedef struct packed {
      logic       op;
      logic       neg;
      logic       err;
      logic [3:0] deg_h;
      logic [3:0] deg_t;
      logic [3:0] deg_o;
      logic [3:0] min_t;
      logic [3:0] min_o;
      logic [3:0] frac_3;
      logic [3:0] frac_2;
      logic [3:0] frac_1;
      logic [3:0] frac_0;
   } ddmm_item_type;

   typedef struct packed {
      logic          valid;
      ddmm_item_type item;
   } ddmm_slot_type;

endpackage

FILE: hw/rtl/ddmm_front.sv
// ============================================================================
// ddmm_front: input pipeline of the coordinate formatter
// Takes angle words, checks the range and splits the magnitude into decimal
// degree, minute and minute-fraction digits. Slots are reserved in the queue
// at accept time, so the pipeline itself never stalls.
// ============================================================================
module ddmm_front
   import ddmm_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic               req_op,
   input  logic signed [31:0] req_angle,
   output logic               req_full,
   input  logic               slot_free,
   output ddmm_slot_type      slot_out
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int NS = 8;

   localparam logic [31:0] LAT_LIMIT  = 32'd900000000;
   localparam logic [31:0] LON_LIMIT  = 32'd1800000000;
   localparam logic [31:0] RECIP_DEG  = 32'd3602879702;
   localparam logic [30:0] UNITS_DEG  = 31'd10000000;
   localparam logic [26:0] FRAC_MUL   = 27'd128849019;
   localparam logic [20:0] RECIP_MIN  = 21'd1717987;
   localparam logic [20:0] MIN_SCALE  = 21'd10000;

   function automatic logic [7:0] split10(input logic [6:0] v);
      logic [14:0] p;
      logic [3:0]  q;
      logic [6:0]  r;
      p = 15'(v) * 15'd205;
      q = p[14:11];
      r = v - 7'({q, 3'b000}) - 7'({q, 1'b0});
      return {q, r[3:0]};
   endfunction

   function automatic logic [7:0] div100(input logic [13:0] v);
      logic [28:0] p;
      p = 29'(v) * 29'd20972;
      return p[28:21];
   endfunction

   function automatic logic [13:0] times100(input logic [7:0] q);
      return 14'({q, 6'b0}) + 14'({q, 5'b0}) + 14'({q, 2'b0});
   endfunction

   logic          accept;
   logic [CW-1:0] count_ff, count_in;
   logic [NS-1:0] valid_ff, valid_in;
   logic [31:0]   angle_u, mag_in;

   logic          op1_ff, neg1_ff;
   logic [31:0]   mag1_ff;
   logic          err1;
   logic [62:0]   prod1;

   logic          op2_ff, neg2_ff, err2_ff;
   logic [30:0]   mag2_ff;
   logic [7:0]    deg2_ff;
   logic [30:0]   frac2;

   logic          op3_ff, neg3_ff, err3_ff;
   logic [7:0]    deg3_ff;
   logic [23:0]   frac3_ff;
   logic [50:0]   prod3;

   logic          op4_ff, neg4_ff, err4_ff;
   logic [7:0]    deg4_ff;
   logic [19:0]   m4_4_ff;
   logic [40:0]   prod4;

   logic          op5_ff, neg5_ff, err5_ff;
   logic [7:0]    deg5_ff;
   logic [19:0]   m4_5_ff;
   logic [6:0]    mins5_ff;
   logic [20:0]   mfrac5;

   logic          op6_ff, neg6_ff, err6_ff;
   logic [7:0]    deg6_ff;
   logic [6:0]    mins6_ff;
   logic [13:0]   mfrac6_ff;
   logic [7:0]    fh6, dh6;
   logic [13:0]   fl6, dl6;

   logic          op7_ff, neg7_ff, err7_ff;
   logic [6:0]    mins7_ff, fh7_ff, fl7_ff, dl7_ff;
   logic [3:0]    dh7_ff;
   ddmm_item_type item7;
   ddmm_item_type item8_ff;

   assign req_full = (count_ff == CW'(DEPTH));
   assign accept   = req_push && !req_full;
   assign valid_in = {valid_ff[NS-2:0], accept};
   assign angle_u  = req_angle;
   assign mag_in   = angle_u[31] ? (~angle_u + 32'd1) : angle_u;

   always_comb begin
      count_in = count_ff;
      if (accept && !slot_free) begin
         count_in = count_ff + CW'(1);
      end else if (!accept && slot_free) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   assign err1  = mag1_ff > (op1_ff ? LON_LIMIT : LAT_LIMIT);
   assign prod1 = 63'(mag1_ff[30:0]) * 63'(RECIP_DEG);
   assign frac2 = mag2_ff - (31'(deg2_ff) * UNITS_DEG);
   assign prod3 = 51'(frac3_ff) * 51'(FRAC_MUL);
   assign prod4 = 41'(m4_4_ff) * 41'(RECIP_MIN);
   assign mfrac5 = 21'(m4_5_ff) - (21'(mins5_ff) * MIN_SCALE);
   assign fh6   = div100(mfrac6_ff);
   assign fl6   = mfrac6_ff - times100(fh6);
   assign dh6   = div100(14'(deg6_ff));
   assign dl6   = 14'(deg6_ff) - times100(dh6);

   always_comb begin
      item7.op    = op7_ff;
      item7.neg   = neg7_ff;
      item7.err   = err7_ff;
      item7.deg_h = dh7_ff;
      {item7.deg_t, item7.deg_o}   = split10(dl7_ff);
      {item7.min_t, item7.min_o}   = split10(mins7_ff);
      {item7.frac_3, item7.frac_2} = split10(fh7_ff);
      {item7.frac_1, item7.frac_0} = split10(fl7_ff);
   end

   always_ff @(posedge clock) begin
      op1_ff    <= req_op;
      neg1_ff   <= angle_u[31];
      mag1_ff   <= mag_in;

      op2_ff    <= op1_ff;
      neg2_ff   <= neg1_ff;
      err2_ff   <= err1;
      mag2_ff   <= mag1_ff[30:0];
      deg2_ff   <= prod1[62:55];

      op3_ff    <= op2_ff;
      neg3_ff   <= neg2_ff;
      err3_ff   <= err2_ff;
      deg3_ff   <= deg2_ff;
      frac3_ff  <= frac2[23:0];

      op4_ff    <= op3_ff;
      neg4_ff   <= neg3_ff;
      err4_ff   <= err3_ff;
      deg4_ff   <= deg3_ff;
      m4_4_ff   <= prod3[50:31];

      op5_ff    <= op4_ff;
      neg5_ff   <= neg4_ff;
      err5_ff   <= err4_ff;
      deg5_ff   <= deg4_ff;
      m4_5_ff   <= m4_4_ff;
      mins5_ff  <= prod4[40:34];

      op6_ff    <= op5_ff;
      neg6_ff   <= neg5_ff;
      err6_ff   <= err5_ff;
      deg6_ff   <= deg5_ff;
      mins6_ff  <= mins5_ff;
      mfrac6_ff <= mfrac5[13:0];

      op7_ff    <= op6_ff;
      neg7_ff   <= neg6_ff;
      err7_ff   <= err6_ff;
      mins7_ff  <= mins6_ff;
      fh7_ff    <= fh6[6:0];
      fl7_ff    <= fl6[6:0];
      dh7_ff    <= dh6[3:0];
      dl7_ff    <= dl6[6:0];

      item8_ff  <= item7;
   end

   assign slot_out.valid = valid_ff[NS-1];
   assign slot_out.item  = item8_ff;

`ifndef SYNTHESIS
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("front: reserved slots exceed queue depth");
`endif

endmodule

FILE: hw/rtl/ddmm_queue.sv
// ============================================================================
// ddmm_queue: decoded word queue
// Small FIFO between the front pipeline and the character sequencer.
// Space is reserved by the front at accept time.
// ============================================================================
module ddmm_queue
   import ddmm_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  ddmm_slot_type in_slot,
   input  logic          pop,
   output ddmm_slot_type out_head
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   ddmm_item_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push, pop_ok;

   assign push   = in_slot.valid;
   assign pop_ok = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop_ok) begin
         count_in = count_ff + CW'(1);
      end else if (!push && pop_ok) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_slot.item;
      end
   end

   assign out_head.valid = (count_ff != '0);
   assign out_head.item  = mem_ff[rd_ptr_ff];

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CW'(DEPTH)) |-> !push || pop_ok)
      else $error("queue: write while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue: read while empty");
`endif

endmodule

FILE: hw/rtl/ddmm_back.sv
// ============================================================================
// ddmm_back: character sequencer
// Walks the head word of the queue into the result register, one character
// per cycle while it is free or popped; the last character frees the word.
// ============================================================================
module ddmm_back
   import ddmm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ddmm_slot_type head,
   output logic          pop,
   output logic          rsp_empty,
   input  logic          rsp_pop,
   output logic [7:0]    rsp_char_code,
   output logic          rsp_last,
   output logic          rsp_range_error
);

   typedef enum logic [3:0] {
      SLOT_HEMI   = 4'd0,
      SLOT_DEG_H  = 4'd1,
      SLOT_DEG_T  = 4'd2,
      SLOT_DEG_O  = 4'd3,
      SLOT_SPACE  = 4'd4,
      SLOT_MIN_T  = 4'd5,
      SLOT_MIN_O  = 4'd6,
      SLOT_DOT    = 4'd7,
      SLOT_FRAC_3 = 4'd8,
      SLOT_FRAC_2 = 4'd9,
      SLOT_FRAC_1 = 4'd10,
      SLOT_FRAC_0 = 4'd11
   } slot_type;

   function automatic logic [7:0] digit(input logic [3:0] d);
      return CHAR_ZERO + {4'b0000, d};
   endfunction

   slot_type      pos_ff, pos_in;
   logic          out_valid_ff, out_valid_in;
   logic [7:0]    char_ff, char_in;
   logic          last_ff, last_in;
   logic          err_ff;
   logic          load;
   ddmm_item_type it;

   assign it      = head.item;
   assign load    = head.valid && (!out_valid_ff || rsp_pop);
   assign last_in = it.err || (pos_ff == SLOT_FRAC_0);
   assign pop     = load && last_in;

   always_comb begin
      unique case (pos_ff)
         SLOT_HEMI: begin
            if (it.op) begin
               char_in = it.neg ? CHAR_W : CHAR_E;
            end else begin
               char_in = it.neg ? CHAR_S : CHAR_N;
            end
         end
         SLOT_DEG_H:  char_in = digit(it.deg_h);
         SLOT_DEG_T:  char_in = digit(it.deg_t);
         SLOT_DEG_O:  char_in = digit(it.deg_o);
         SLOT_SPACE:  char_in = CHAR_SPACE;
         SLOT_MIN_T:  char_in = digit(it.min_t);
         SLOT_MIN_O:  char_in = digit(it.min_o);
         SLOT_DOT:    char_in = CHAR_DOT;
         SLOT_FRAC_3: char_in = digit(it.frac_3);
         SLOT_FRAC_2: char_in = digit(it.frac_2);
         SLOT_FRAC_1: char_in = digit(it.frac_1);
         SLOT_FRAC_0: char_in = digit(it.frac_0);
         default:     char_in = CHAR_NUL;
      endcase
      if (it.err) begin
         char_in = CHAR_NUL;
      end
   end

   always_comb begin
      pos_in       = pos_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
         if (last_in) begin
            pos_in = SLOT_HEMI;
         end else if ((pos_ff == SLOT_HEMI) && !it.op) begin
            pos_in = SLOT_DEG_T;
         end else begin
            pos_in = slot_type'(pos_ff + 4'd1);
         end
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= SLOT_HEMI;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= char_in;
         last_ff <= last_in;
         err_ff  <= it.err;
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_char_code   = char_ff;
   assign rsp_last        = last_ff;
   assign rsp_range_error = err_ff;

`ifndef SYNTHESIS
   a_err_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && err_ff) |-> last_ff)
      else $error("back: error word without last mark");
`endif

endmodule

FILE: hw/rtl/coordinate_to_ddmm_ascii_unit.sv
// ============================================================================
// coordinate_to_ddmm_ascii_unit: angle to DDMM.MMMM ASCII text formatter
// Turns a signed angle (1e-7 degree units) into hemisphere, degrees, minutes
// and minute fraction text, one character per result word.
// ============================================================================
// Input channel: req_op selects latitude (0) or longitude (1); req_angle is
// taken when req_push is high and req_full is low.
// Result channel: one character per word while rsp_empty is low, taken with
// rsp_pop. Latitude gives 11 words, longitude 12, an out-of-range angle one
// error word (code 0, last and range_error set).
// An angle's first character reaches the result ports through the 8 digit
// pipeline stages (the accept edge loads the first), the queue write and
// the result register; it can be popped as soon as it is shown.
// Throughput: one character per cycle while the receiver pops, set by the
// single character sequencer; later angles wait in the queue until it is free.
// DEPTH words can be in flight between the input and the sequencer; req_full
// rises when all are reserved.
// A stalled receiver holds the current character; the queue fills and then
// req_full holds off new angles. Nothing is lost.
// Reset empties pipeline, queue and result register and rewinds the sequencer.
// ============================================================================
module coordinate_to_ddmm_ascii_unit
   import ddmm_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_op,
   input  logic signed [31:0] req_angle,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [7:0]         rsp_char_code,
   output logic               rsp_last,
   output logic               rsp_range_error
);

   ddmm_slot_type front_slot;
   ddmm_slot_type queue_head;
   logic          queue_pop;

   ddmm_front #(
      .DEPTH (DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_op    (req_op),
      .req_angle (req_angle),
      .req_full  (req_full),
      .slot_free (queue_pop),
      .slot_out  (front_slot)
   );

   ddmm_queue #(
      .DEPTH (DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_slot  (front_slot),
      .pop      (queue_pop),
      .out_head (queue_head)
   );

   ddmm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (queue_head),
      .pop             (queue_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_char_code   (rsp_char_code),
      .rsp_last        (rsp_last),
      .rsp_range_error (rsp_range_error)
   );

endmodule

FILE: bench/tb_coordinate_to_ddmm_ascii_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_coordinate_to_ddmm_ascii_unit: self-checking bench for the DDMM formatter
// Pushes latitude and longitude angles with random gaps and pops the text
// words under random stalls. Every popped word is checked against text
// predicted from the angle: hemisphere, degrees, minutes and the truncated
// minute fraction, or the single range error word.
// ============================================================================
module tb_coordinate_to_ddmm_ascii_unit;
   import ddmm_pkg::*;

   localparam logic        OP_LATITUDE   = 1'b0;
   localparam logic        OP_LONGITUDE  = 1'b1;
   localparam logic [31:0] UNITS_PER_DEG = 32'd10000000;
   localparam logic [31:0] LAT_LIMIT     = 32'd900000000;
   localparam logic [31:0] LON_LIMIT     = 32'd1800000000;
   localparam int          RANDOM_ITEMS  = 100;
   localparam int          CALM_ITEMS    = 25;
   localparam int          DRAIN_CYCLES  = 40;
   localparam int          PRINT_CAP     = 40;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last;
      logic       range_error;
   } text_word_type;

   class ddmm_text_scoreboard;
      text_word_type expected_text[$];
      int unsigned   errors;
      int unsigned   words_checked;
      int unsigned   lat_count;
      int unsigned   lon_count;
      int unsigned   rejected_count;

      function logic [7:0] digit(input logic [31:0] v);
         return CHAR_ZERO + 8'(v % 10);
      endfunction

      // Builds the expected text of one accepted angle.
      function void note_angle(input logic op, input logic [31:0] angle);
         logic          neg;
         logic [31:0]   mag, limit, deg, frac, m4, mins, mfrac;
         logic [7:0]    txt[12];
         int            n;
         text_word_type w;
         neg   = angle[31];
         mag   = neg ? (32'd0 - angle) : angle;
         limit = (op == OP_LONGITUDE) ? LON_LIMIT : LAT_LIMIT;
         if (mag > limit) begin
            w.char_code   = CHAR_NUL;
            w.last        = 1'b1;
            w.range_error = 1'b1;
            expected_text.push_back(w);
            rejected_count++;
            return;
         end
         deg   = mag / UNITS_PER_DEG;
         frac  = mag % UNITS_PER_DEG;
         m4    = (frac * 32'd6) / 32'd100;
         mins  = m4 / 32'd10000;
         mfrac = m4 % 32'd10000;
         n = 0;
         if (op == OP_LONGITUDE) begin
            txt[n++] = neg ? CHAR_W : CHAR_E;
            txt[n++] = digit(deg / 100);
            lon_count++;
         end else begin
            txt[n++] = neg ? CHAR_S : CHAR_N;
            lat_count++;
         end
         txt[n++] = digit(deg / 10);
         txt[n++] = digit(deg);
         txt[n++] = CHAR_SPACE;
         txt[n++] = digit(mins / 10);
         txt[n++] = digit(mins);
         txt[n++] = CHAR_DOT;
         txt[n++] = digit(mfrac / 1000);
         txt[n++] = digit(mfrac / 100);
         txt[n++] = digit(mfrac / 10);
         txt[n++] = digit(mfrac);
         for (int k = 0; k < n; k++) begin
            w.char_code   = txt[k];
            w.last        = (k == n - 1);
            w.range_error = 1'b0;
            expected_text.push_back(w);
         end
      endfunction

      task report(input string msg);
         if (errors < PRINT_CAP) $display("%t MISMATCH: %s", $realtime, msg);
         errors++;
      endtask

      task check_word(input logic [7:0] ch, input logic last, input logic err);
         text_word_type want;
         if (expected_text.size() == 0) begin
            report($sformatf("unexpected word char 0x%02h last %b range_error %b",
                             ch, last, err));
            return;
         end
         want = expected_text.pop_front();
         words_checked++;
         if (ch !== want.char_code)
            report($sformatf("char_code 0x%02h, want 0x%02h", ch, want.char_code));
         if (last !== want.last)
            report($sformatf("last %b, want %b (char 0x%02h)", last, want.last,
                             want.char_code));
         if (err !== want.range_error)
            report($sformatf("range_error %b, want %b", err, want.range_error));
      endtask

      function int pending();
         return expected_text.size();
      endfunction
   endclass

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_push        = 1'b0;
   logic        req_full;
   logic        req_op          = 1'b0;
   logic [31:0] req_angle       = 32'd0;
   logic        rsp_empty;
   logic        rsp_pop         = 1'b0;
   logic [7:0]  rsp_char_code;
   logic        rsp_last;
   logic        rsp_range_error;

   ddmm_text_scoreboard sb;
   int gap_odds   = 30;
   int stall_odds = 30;

   coordinate_to_ddmm_ascii_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_op          (req_op),
      .req_angle       (req_angle),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_char_code   (rsp_char_code),
      .rsp_last        (rsp_last),
      .rsp_range_error (rsp_range_error)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_push && !req_full) sb.note_angle(req_op, req_angle);
      if (!reset && rsp_pop && !rsp_empty)
         sb.check_word(rsp_char_code, rsp_last, rsp_range_error);
   end

   task send_angle(input logic op, input logic [31:0] angle);
      if ($urandom_range(99) < gap_odds) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_push  <= 1'b1;
      req_op    <= op;
      req_angle <= angle;
      do @(posedge clock); while (req_full);
   endtask

   task send_random_angle();
      logic        op;
      logic [31:0] limit, mag, angle;
      int          kind;
      op    = 1'($urandom_range(0, 1));
      limit = (op == OP_LONGITUDE) ? LON_LIMIT : LAT_LIMIT;
      kind  = $urandom_range(0, 9);
      if (kind < 7)
         mag = $urandom_range(0, limit);
      else if (kind < 8)
         mag = limit - 32'd2 + $urandom_range(0, 4);
      else
         mag = $urandom();
      angle = ($urandom_range(0, 1) != 0) ? (32'd0 - mag) : mag;
      send_angle(op, angle);
   endtask

   // result side: random stall bursts, otherwise pop held high
   initial begin
      @(negedge reset);
      forever begin
         if ($urandom_range(99) < stall_odds) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
      end
   end

   initial begin
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_angle(OP_LATITUDE,  32'd0);
      send_angle(OP_LONGITUDE, 32'd0);
      send_angle(OP_LATITUDE,  LAT_LIMIT);
      send_angle(OP_LATITUDE,  32'd0 - LAT_LIMIT);
      send_angle(OP_LATITUDE,  LAT_LIMIT + 32'd1);
      send_angle(OP_LATITUDE,  32'd0 - LAT_LIMIT - 32'd1);
      send_angle(OP_LONGITUDE, LON_LIMIT);
      send_angle(OP_LONGITUDE, 32'd0 - LON_LIMIT);
      send_angle(OP_LONGITUDE, LON_LIMIT + 32'd1);
      send_angle(OP_LONGITUDE, 32'd0 - LON_LIMIT - 32'd1);
      send_angle(OP_LATITUDE,  32'h8000_0000);
      send_angle(OP_LONGITUDE, 32'h8000_0000);
      send_angle(OP_LATITUDE,  32'h7FFF_FFFF);
      send_angle(OP_LONGITUDE, 32'h7FFF_FFFF);
      send_angle(OP_LATITUDE,  32'hFFFF_FFFF);
      send_angle(OP_LONGITUDE, 32'd1);
      send_angle(OP_LATITUDE,  32'd9999999);
      send_angle(OP_LONGITUDE, 32'd0 - 32'd9999999);
      send_angle(OP_LATITUDE,  32'd123456789);
      send_angle(OP_LONGITUDE, 32'd0 - 32'd1234567890);
      send_angle(OP_LATITUDE,  LAT_LIMIT - 32'd1);
      send_angle(OP_LONGITUDE, LON_LIMIT - 32'd1);
      send_angle(OP_LONGITUDE, 32'd1000000000);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i >= RANDOM_ITEMS - CALM_ITEMS) begin
            gap_odds   = 0;
            stall_odds = 0;
         end else if (i % 16 == 0) begin
            case ($urandom_range(0, 2))
               0: begin gap_odds = 0;  stall_odds = 0;  end
               1: begin gap_odds = 25; stall_odds = 25; end
               default: begin gap_odds = 60; stall_odds = 60; end
            endcase
         end
         send_random_angle();
      end
      req_push <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Formatted %0d latitude and %0d longitude angles, rejected %0d out of range;",
               sb.lat_count, sb.lon_count, sb.rejected_count);
      $display("%0d text words checked under random push gaps and pop stalls.",
               sb.words_checked);
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timeout with %0d words still expected", sb.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/ddmm_pkg.sv
hw/rtl/ddmm_front.sv
hw/rtl/ddmm_queue.sv
hw/rtl/ddmm_back.sv
hw/rtl/coordinate_to_ddmm_ascii_unit.sv
bench/tb_coordinate_to_ddmm_ascii_unit.sv
